// ===== hdl/backward_lz_decompressor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the backward LZ decompressor
// Concurrent checks on the block's internal logic. Defining NO_ASSERTIONS
// leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef BACKWARD_LZ_DECOMPRESSOR_ASSERT_SVH
`define BACKWARD_LZ_DECOMPRESSOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BLZ_ASSERT_IMPLIES(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("blz assertion failed");
`define BLZ_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("blz assertion failed");
`else
`define BLZ_ASSERT_IMPLIES(label, clk, rstn, cond, expr)
`define BLZ_ASSERT_NEXT(label, clk, rstn, cond, expr)
`endif
`endif

// ===== hdl/blz_pkg.sv =====
// ----------------------------------------------------------------------------
// Backward LZ decompressor package
// Shared constants, status codes and the command passed from the token
// decoder to the byte expander.
// ----------------------------------------------------------------------------
package blz_pkg;

    localparam int CFG_W       = 24;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_DECODED_LENGTH    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSED_LENGTH = 1'b1;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam int DIST_W  = 13;
    localparam int COUNT_W = 5;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_REF   = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_COMPLETE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_LIT    = 2'd1,
        CMD_COPY   = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic [DIST_W-1:0]  offset;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } cmd_t;

endpackage

// ===== hdl/backward_lz_decompressor.sv =====
// ----------------------------------------------------------------------------
// Backward LZ decompressor
// Decodes a backward LZ stream fed from its end toward its start and emits
// the decoded bytes in the same reversed order.
// ----------------------------------------------------------------------------
// The token decoder handles one compressed byte at a time: it accepts the
// byte, classifies it against the flag bits and the stream counters,
// updates the written-byte count and hands a command to a four-entry queue.
// The byte expander behind the queue produces one result per cycle unless
// the output stalls, limited by the single read port of the history memory,
// so a back-reference of up to 18 bytes is copied while the decoder keeps
// filling the queue. Every result carries a byte-valid flag and a status;
// the final result that an input byte causes has tlast set, and only it
// carries a nonzero status. The history memory is not cleared after reset.
module backward_lz_decompressor #(
    parameter int HISTORY_DEPTH = 8192,
    parameter int LENGTH_WIDTH  = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [blz_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [blz_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [blz_pkg::S_DATA_W-1:0]    s_tdata,   // data_byte
    input  logic                            s_tuser,   // start_stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [blz_pkg::M_DATA_W-1:0]    m_tdata,   // out_byte, byte_valid, status
    output logic                            m_tlast
);
    import blz_pkg::*;

    cmd_t push_data, head;
    logic push, full, pop, empty;

    blz_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_push  (push),
        .cmd_data  (push_data),
        .cmd_full  (full)
    );

    blz_cmd_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    blz_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!empty),
        .cmd_data  (head),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hdl/blz_front.sv =====
// ----------------------------------------------------------------------------
// Backward LZ token decoder
// Accepts compressed bytes, tracks flag bits and stream counters, and turns
// each byte into at most one command for the byte expander.
// ----------------------------------------------------------------------------
`include "backward_lz_decompressor_assert.svh"

module blz_front #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [blz_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [blz_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [blz_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                             s_tuser,
    output logic                             cmd_push,
    output blz_pkg::cmd_t                    cmd_data,
    input  logic                             cmd_full
);
    import blz_pkg::*;

    localparam int CMP_W = (LENGTH_WIDTH > CFG_W) ? LENGTH_WIDTH : CFG_W;
    localparam logic [7:0]         FLAG_FIRST  = 8'h80;
    localparam logic [7:0]         FLAG_LAST   = 8'h01;
    localparam logic [COUNT_W-1:0] LEN_BIAS    = 5'd3;
    localparam logic [DIST_W-1:0]  DIST_BIAS   = 13'd3;
    localparam logic [DIST_W-1:0]  CLAMP_DIST  = 13'd2;
    localparam logic [COUNT_W-1:0] MAX_COPY    = 5'd18;

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_DECODE = 4'b0010,
        F_COUNT  = 4'b0100,
        F_FINAL  = 4'b1000
    } front_state_t;

    typedef enum logic [3:0] {
        PH_FLAG   = 4'b0001,
        PH_TOKEN  = 4'b0010,
        PH_SECOND = 4'b0100,
        PH_HALT   = 4'b1000
    } phase_t;

    front_state_t            state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [CFG_W-1:0]        decoded_length_reg, decoded_length_next;
    logic [CFG_W-1:0]        compressed_length_reg, compressed_length_next;
    logic [LENGTH_WIDTH-1:0] bw_reg, bw_next;
    logic [LENGTH_WIDTH-1:0] bc_reg, bc_next;
    logic [7:0]              flag_bits_reg, flag_bits_next;
    logic [7:0]              flag_mask_reg, flag_mask_next;
    logic [7:0]              held_reg, held_next;
    status_t                 halt_code_reg, halt_code_next;

    logic [7:0]              in_byte_reg, in_byte_next;
    cmd_kind_t               kind_reg, kind_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic                    fixed_reg, fixed_next;
    status_t                 fixed_status_reg, fixed_status_next;

    logic [CMP_W-1:0]        bw_ext, bc_ext, dl_ext, cl_ext, rem;
    logic                    written_full, budget_spent;
    logic [COUNT_W-1:0]      copy_len;
    logic [DIST_W-1:0]       dist_raw;
    logic                    dist_far, few_written, rem_short, flag_set;
    phase_t                  nt_phase;
    logic [7:0]              nt_mask;
    status_t                 final_status;

    assign bw_ext       = CMP_W'(bw_reg);
    assign bc_ext       = CMP_W'(bc_reg);
    assign dl_ext       = CMP_W'(decoded_length_reg);
    assign cl_ext       = CMP_W'(compressed_length_reg);
    assign written_full = bw_ext >= dl_ext;
    assign budget_spent = bc_ext >= cl_ext;
    assign rem          = dl_ext - bw_ext;
    assign copy_len     = {1'b0, held_reg[7:4]} + LEN_BIAS;
    assign dist_raw     = {1'b0, held_reg[3:0], in_byte_reg} + DIST_BIAS;
    assign dist_far     = CMP_W'(dist_raw) > bw_ext;
    assign few_written  = bw_ext < CMP_W'(2);
    assign rem_short    = rem < CMP_W'(copy_len);
    assign flag_set     = (flag_bits_reg & flag_mask_reg) != 8'h00;
    assign nt_phase     = (flag_mask_reg == FLAG_LAST) ? PH_FLAG : PH_TOKEN;
    assign nt_mask      = (flag_mask_reg == FLAG_LAST) ? flag_mask_reg : (flag_mask_reg >> 1);

    assign s_tready = (state_reg == F_IDLE);

    always_comb begin
        if (fixed_reg) begin
            final_status = fixed_status_reg;
        end else if (written_full) begin
            final_status = ST_COMPLETE;
        end else if (budget_spent) begin
            final_status = ST_TRUNCATED;
        end else begin
            final_status = ST_OK;
        end
    end

    always_comb begin
        cmd_data.kind   = (kind_reg == CMD_NONE) ? CMD_STATUS : kind_reg;
        cmd_data.data   = in_byte_reg;
        cmd_data.offset = dist_reg;
        cmd_data.count  = count_reg;
        cmd_data.status = final_status;
    end

    always_comb begin
        state_next             = state_reg;
        phase_next             = phase_reg;
        decoded_length_next    = decoded_length_reg;
        compressed_length_next = compressed_length_reg;
        bw_next                = bw_reg;
        bc_next                = bc_reg;
        flag_bits_next         = flag_bits_reg;
        flag_mask_next         = flag_mask_reg;
        held_next              = held_reg;
        halt_code_next         = halt_code_reg;
        in_byte_next           = in_byte_reg;
        kind_next              = kind_reg;
        count_next             = count_reg;
        dist_next              = dist_reg;
        fixed_next             = fixed_reg;
        fixed_status_next      = fixed_status_reg;
        cmd_push               = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_DECODED_LENGTH: begin
                    decoded_length_next = cfg_wdata;
                end
                REG_COMPRESSED_LENGTH: begin
                    compressed_length_next = cfg_wdata;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    in_byte_next = s_tdata;
                    state_next   = F_DECODE;
                    if (s_tuser) begin
                        bw_next        = '0;
                        bc_next        = '0;
                        flag_bits_next = 8'h00;
                        flag_mask_next = FLAG_LAST;
                        phase_next     = PH_FLAG;
                        held_next      = 8'h00;
                        halt_code_next = ST_OK;
                    end
                end
            end
            F_DECODE: begin
                kind_next  = CMD_NONE;
                count_next = '0;
                dist_next  = dist_raw;
                fixed_next = 1'b0;
                state_next = F_COUNT;
                if (phase_reg == PH_HALT) begin
                    fixed_next        = 1'b1;
                    fixed_status_next = halt_code_reg;
                    kind_next         = CMD_STATUS;
                    state_next        = F_FINAL;
                end else if (written_full || budget_spent) begin
                    fixed_next        = 1'b1;
                    fixed_status_next = written_full ? ST_COMPLETE : ST_TRUNCATED;
                    halt_code_next    = written_full ? ST_COMPLETE : ST_TRUNCATED;
                    phase_next        = PH_HALT;
                    kind_next         = CMD_STATUS;
                    state_next        = F_FINAL;
                end else begin
                    bc_next = bc_reg + LENGTH_WIDTH'(1);
                    case (phase_reg)
                        PH_FLAG: begin
                            flag_bits_next = in_byte_reg;
                            flag_mask_next = FLAG_FIRST;
                            phase_next     = PH_TOKEN;
                        end
                        PH_TOKEN: begin
                            if (!flag_set) begin
                                kind_next      = CMD_LIT;
                                count_next     = COUNT_W'(1);
                                phase_next     = nt_phase;
                                flag_mask_next = nt_mask;
                            end else begin
                                held_next  = in_byte_reg;
                                phase_next = PH_SECOND;
                            end
                        end
                        PH_SECOND: begin
                            if (dist_far && few_written) begin
                                fixed_next        = 1'b1;
                                fixed_status_next = ST_BAD_REF;
                                halt_code_next    = ST_BAD_REF;
                                phase_next        = PH_HALT;
                                kind_next         = CMD_STATUS;
                                state_next        = F_FINAL;
                            end else begin
                                kind_next      = CMD_COPY;
                                dist_next      = dist_far ? CLAMP_DIST : dist_raw;
                                count_next     = rem_short ? rem[COUNT_W-1:0] : copy_len;
                                phase_next     = nt_phase;
                                flag_mask_next = nt_mask;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            F_COUNT: begin
                bw_next    = bw_reg + LENGTH_WIDTH'(count_reg);
                state_next = F_FINAL;
            end
            F_FINAL: begin
                if (kind_reg == CMD_NONE && final_status == ST_OK) begin
                    state_next = F_IDLE;
                end else if (!cmd_full) begin
                    cmd_push   = 1'b1;
                    state_next = F_IDLE;
                    if (!fixed_reg && final_status != ST_OK) begin
                        phase_next     = PH_HALT;
                        halt_code_next = final_status;
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= F_IDLE;
            phase_reg             <= PH_FLAG;
            decoded_length_reg    <= '0;
            compressed_length_reg <= '0;
            bw_reg                <= '0;
            bc_reg                <= '0;
            flag_bits_reg         <= 8'h00;
            flag_mask_reg         <= FLAG_LAST;
            held_reg              <= 8'h00;
            halt_code_reg         <= ST_OK;
        end else begin
            state_reg             <= state_next;
            phase_reg             <= phase_next;
            decoded_length_reg    <= decoded_length_next;
            compressed_length_reg <= compressed_length_next;
            bw_reg                <= bw_next;
            bc_reg                <= bc_next;
            flag_bits_reg         <= flag_bits_next;
            flag_mask_reg         <= flag_mask_next;
            held_reg              <= held_next;
            halt_code_reg         <= halt_code_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg      <= in_byte_next;
        kind_reg         <= kind_next;
        count_reg        <= count_next;
        dist_reg         <= dist_next;
        fixed_reg        <= fixed_next;
        fixed_status_reg <= fixed_status_next;
    end

    `BLZ_ASSERT_IMPLIES(a_copy_count_range, aclk, aresetn, cmd_push && cmd_data.kind == CMD_COPY, cmd_data.count != '0 && cmd_data.count <= MAX_COPY)
    `BLZ_ASSERT_NEXT(a_halt_after_status, aclk, aresetn, cmd_push && cmd_data.status != ST_OK, phase_reg == PH_HALT)

endmodule

// ===== hdl/blz_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Backward LZ command queue
// A short queue of decoded commands between the token decoder and the
// byte expander.
// ----------------------------------------------------------------------------
`include "backward_lz_decompressor_assert.svh"

module blz_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  blz_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output blz_pkg::cmd_t head,
    output logic          empty
);
    import blz_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10: begin
                fill_next = fill_reg + 1'b1;
            end
            2'b01: begin
                fill_next = fill_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BLZ_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, !full)
    `BLZ_ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, !empty)

endmodule

// ===== hdl/blz_back.sv =====
// ----------------------------------------------------------------------------
// Backward LZ byte expander
// Carries out literal, copy and status commands, keeps the history memory
// and drives the result channel through an output register.
// ----------------------------------------------------------------------------
`include "backward_lz_decompressor_assert.svh"

module blz_back #(
    parameter int HISTORY_DEPTH = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    input  blz_pkg::cmd_t                cmd_data,
    output logic                         cmd_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [blz_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import blz_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);

    logic [7:0] hist_mem [HISTORY_DEPTH];

    logic [PTR_W-1:0]   aw_ptr_reg, aw_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               active_reg, active_next;
    status_t            copy_status_reg, copy_status_next;
    logic [7:0]         rd_data_reg;

    logic               pend_reg, pend_next;
    logic               pend_lit_reg, pend_lit_next;
    logic [7:0]         pend_byte_reg, pend_byte_next;
    logic               pend_bvalid_reg, pend_bvalid_next;
    logic               pend_last_reg, pend_last_next;
    status_t            pend_status_reg, pend_status_next;
    logic [PTR_W-1:0]   pend_addr_reg, pend_addr_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_bvalid_reg, out_bvalid_next;
    logic               out_last_reg, out_last_next;
    status_t            out_status_reg, out_status_next;

    logic               out_free, advance, consume, rd_en, wr_en;
    logic [7:0]         wr_byte;
    logic [PTR_W:0]     aw_x, dist_x;
    logic [PTR_W-1:0]   copy_start;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = !pend_reg || out_free;
    assign consume  = pend_reg && out_free;
    assign rd_en    = advance && active_reg;
    assign cmd_pop  = advance && !active_reg && cmd_valid;
    assign wr_en    = consume && pend_bvalid_reg;
    assign wr_byte  = pend_lit_reg ? pend_byte_reg : rd_data_reg;

    assign aw_x       = {1'b0, aw_ptr_reg};
    assign dist_x     = (PTR_W + 1)'(cmd_data.offset);
    assign copy_start = (aw_x >= dist_x) ? PTR_W'(aw_x - dist_x)
                                         : PTR_W'(aw_x + (PTR_W + 1)'(HISTORY_DEPTH) - dist_x);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - 11){1'b0}}, out_status_reg, out_bvalid_reg, out_byte_reg};

    always_comb begin
        aw_ptr_next      = aw_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        cnt_next         = cnt_reg;
        active_next      = active_reg;
        copy_status_next = copy_status_reg;
        pend_next        = pend_reg;
        pend_lit_next    = pend_lit_reg;
        pend_byte_next   = pend_byte_reg;
        pend_bvalid_next = pend_bvalid_reg;
        pend_last_next   = pend_last_reg;
        pend_status_next = pend_status_reg;
        pend_addr_next   = pend_addr_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_bvalid_next  = out_bvalid_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;

        if (consume) begin
            out_valid_next  = 1'b1;
            out_byte_next   = wr_byte;
            out_bvalid_next = pend_bvalid_reg;
            out_last_next   = pend_last_reg;
            out_status_next = pend_status_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (advance) begin
            pend_next = 1'b0;
        end

        if (rd_en) begin
            pend_next        = 1'b1;
            pend_lit_next    = 1'b0;
            pend_bvalid_next = 1'b1;
            pend_addr_next   = aw_ptr_reg;
            pend_last_next   = (cnt_reg == COUNT_W'(1));
            pend_status_next = (cnt_reg == COUNT_W'(1)) ? copy_status_reg : ST_OK;
            aw_ptr_next      = ptr_inc(aw_ptr_reg);
            rd_ptr_next      = ptr_inc(rd_ptr_reg);
            cnt_next         = cnt_reg - 1'b1;
            active_next      = (cnt_reg != COUNT_W'(1));
        end else if (cmd_pop) begin
            case (cmd_data.kind)
                CMD_LIT: begin
                    pend_next        = 1'b1;
                    pend_lit_next    = 1'b1;
                    pend_byte_next   = cmd_data.data;
                    pend_bvalid_next = 1'b1;
                    pend_addr_next   = aw_ptr_reg;
                    pend_last_next   = 1'b1;
                    pend_status_next = cmd_data.status;
                    aw_ptr_next      = ptr_inc(aw_ptr_reg);
                end
                CMD_COPY: begin
                    active_next      = (cmd_data.count != '0);
                    cnt_next         = cmd_data.count;
                    copy_status_next = cmd_data.status;
                    rd_ptr_next      = copy_start;
                end
                default: begin
                    pend_next        = 1'b1;
                    pend_lit_next    = 1'b1;
                    pend_byte_next   = 8'h00;
                    pend_bvalid_next = 1'b0;
                    pend_last_next   = 1'b1;
                    pend_status_next = cmd_data.status;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aw_ptr_reg    <= '0;
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            aw_ptr_reg    <= aw_ptr_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg      <= rd_ptr_next;
        cnt_reg         <= cnt_next;
        copy_status_reg <= copy_status_next;
        pend_lit_reg    <= pend_lit_next;
        pend_byte_reg   <= pend_byte_next;
        pend_bvalid_reg <= pend_bvalid_next;
        pend_last_reg   <= pend_last_next;
        pend_status_reg <= pend_status_next;
        pend_addr_reg   <= pend_addr_next;
        out_byte_reg    <= out_byte_next;
        out_bvalid_reg  <= out_bvalid_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[pend_addr_reg] <= wr_byte;
        end
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_ptr_reg];
        end
    end

    `BLZ_ASSERT_IMPLIES(a_no_read_on_stall, aclk, aresetn, pend_reg && !out_free, !rd_en)
    `BLZ_ASSERT_IMPLIES(a_copy_count_live, aclk, aresetn, active_reg, cnt_reg != '0)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backward LZ decompressor testbench
// Feeds directed and random compressed streams through the decoder under
// several length settings and flow-control patterns. A behavioral decoder
// predicts every result when its input transfer is accepted, and each
// result transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import blz_pkg::*;

    localparam int HIST_DEPTH  = 8192;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_TAIL  = 24;
    localparam logic [CFG_W-1:0] LEN_MAX = {CFG_W{1'b1}};

    typedef struct {
        logic [7:0] data;
        logic       start;
    } comp_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
        status_t    status;
    } decoded_t;

    typedef enum logic [1:0] {
        WANT_FLAG,
        WANT_TOKEN,
        WANT_SECOND,
        HALTED
    } dec_phase_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;   // data_byte
    logic                   s_tuser = 1'b0; // start_stream
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;        // out_byte, byte_valid, status
    logic                   m_tlast;

    comp_byte_t comp_bytes[$];
    decoded_t   decoded_due[$];
    decoded_t   step_out[$];
    int         mismatches = 0;
    int         stall_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         queued_bytes = 0;
    int unsigned gen_out = 0;

    // Behavioral decoder state.
    logic [7:0]  hist_mem [0:HIST_DEPTH-1];
    logic [23:0] want_len = '0;
    logic [23:0] budget = '0;
    logic [23:0] out_count = '0;
    logic [23:0] in_count = '0;
    logic [7:0]  flag_reg = '0;
    logic [7:0]  flag_sel = 8'h01;
    dec_phase_t  dec_phase = WANT_FLAG;
    logic [7:0]  pair_head = '0;
    status_t     halt_status = ST_OK;

    backward_lz_decompressor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("tb: %s mismatch: got 0x%0h, expected 0x%0h", what, got, want);
        end
    endtask

    function automatic void clear_stream();
        out_count   = '0;
        in_count    = '0;
        flag_reg    = '0;
        flag_sel    = 8'h01;
        dec_phase   = WANT_FLAG;
        pair_head   = '0;
        halt_status = ST_OK;
    endfunction

    function automatic void put_byte(input logic [7:0] v);
        hist_mem[out_count % HIST_DEPTH] = v;
        out_count = out_count + 1'b1;
        step_out.push_back('{data: v, valid: 1'b1, last: 1'b0, status: ST_OK});
    endfunction

    function automatic void advance_token();
        if (flag_sel == 8'h01) begin
            dec_phase = WANT_FLAG;
        end else begin
            flag_sel  = flag_sel >> 1;
            dec_phase = WANT_TOKEN;
        end
    endfunction

    task automatic decode_step(input logic [7:0] b, input logic start);
        int unsigned run_len;
        int unsigned offset;
        int unsigned i;
        bit          halt;
        status_t     code;
        halt = 1'b0;
        code = ST_OK;
        step_out.delete();
        if (start) begin
            clear_stream();
        end
        if (dec_phase == HALTED) begin
            halt = 1'b1;
            code = halt_status;
        end else if (out_count >= want_len) begin
            halt = 1'b1;
            code = ST_COMPLETE;
        end else if (in_count >= budget) begin
            halt = 1'b1;
            code = ST_TRUNCATED;
        end else begin
            in_count = in_count + 1'b1;
            case (dec_phase)
                WANT_FLAG: begin
                    flag_reg  = b;
                    flag_sel  = 8'h80;
                    dec_phase = WANT_TOKEN;
                end
                WANT_TOKEN: begin
                    if ((flag_reg & flag_sel) == 8'h00) begin
                        put_byte(b);
                        advance_token();
                    end else begin
                        pair_head = b;
                        dec_phase = WANT_SECOND;
                    end
                end
                default: begin
                    run_len = pair_head[7:4] + 3;
                    offset  = {pair_head[3:0], b} + 3;
                    if (offset > out_count) begin
                        if (out_count < 2) begin
                            halt = 1'b1;
                            code = ST_BAD_REF;
                        end else begin
                            offset = 2;
                        end
                    end
                    if (!halt) begin
                        for (i = 0; i < run_len && out_count < want_len; i++) begin
                            put_byte(hist_mem[(out_count - offset) % HIST_DEPTH]);
                        end
                        advance_token();
                    end
                end
            endcase
            if (!halt) begin
                if (out_count >= want_len) begin
                    halt = 1'b1;
                    code = ST_COMPLETE;
                end else if (in_count >= budget) begin
                    halt = 1'b1;
                    code = ST_TRUNCATED;
                end
            end
        end
        if (halt) begin
            dec_phase   = HALTED;
            halt_status = code;
            if (step_out.size() == 0) begin
                step_out.push_back('{data: 8'h00, valid: 1'b0, last: 1'b0, status: ST_OK});
            end
            step_out[step_out.size()-1].status = code;
            step_out[step_out.size()-1].last   = 1'b1;
        end else if (step_out.size() != 0) begin
            step_out[step_out.size()-1].last = 1'b1;
        end
        foreach (step_out[k]) begin
            decoded_due.push_back(step_out[k]);
        end
    endtask

    // Sender: predicts on every accepted transfer, then presents the next byte.
    always @(posedge aclk) begin : feeder
        comp_byte_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_step(s_tdata, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (comp_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = comp_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.data;
                    s_tuser  <= item.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result transfer against the oldest prediction.
    always @(posedge aclk) begin : result_check
        decoded_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_due.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = decoded_due.pop_front();
                    if (m_tdata[7:0] !== want.data)
                        report_mismatch("out_byte", m_tdata[7:0], want.data);
                    if (m_tdata[8] !== want.valid)
                        report_mismatch("byte_valid", m_tdata[8], want.valid);
                    if (m_tdata[10:9] !== want.status)
                        report_mismatch("status", m_tdata[10:9], want.status);
                    if (m_tdata[15:11] !== '0)
                        report_mismatch("tdata padding", m_tdata[15:11], 0);
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", m_tlast, want.last);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("tb: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb: errors");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_DECODED_LENGTH) begin
            want_len = val;
        end else begin
            budget = val;
        end
    endtask

    task automatic set_lengths(input logic [CFG_W-1:0] dec_len, input logic [CFG_W-1:0] comp_len);
        write_reg(REG_DECODED_LENGTH, dec_len);
        write_reg(REG_COMPRESSED_LENGTH, comp_len);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] data, input logic start);
        comp_bytes.push_back('{data: data, start: start});
        queued_bytes++;
    endtask

    task automatic settle(input int tail);
        while (comp_bytes.size() != 0 || s_tvalid || decoded_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (tail) @(posedge aclk);
    endtask

    // Builds flag groups; early tokens of a fresh stream are mostly
    // literals so that back-references have history to copy from.
    task automatic add_stream(input bit fresh, input int groups);
        logic [7:0]  flags;
        logic [3:0]  nib;
        logic [11:0] offset;
        int          g;
        int          k;
        if (fresh) begin
            gen_out = 0;
        end
        for (g = 0; g < groups; g++) begin
            flags = 8'($urandom_range(255));
            if (fresh && g == 0 && $urandom_range(9) != 0) begin
                flags = flags & 8'h3f;
            end
            push_byte(flags, fresh && g == 0);
            for (k = 7; k >= 0; k--) begin
                if ($urandom_range(39) == 0) begin
                    return;
                end
                if (flags[k]) begin
                    nib = 4'($urandom_range(15));
                    if (gen_out >= 3 && $urandom_range(3) != 0) begin
                        offset = 12'($urandom_range((gen_out - 3 > 4095) ? 4095 : gen_out - 3));
                    end else begin
                        offset = 12'($urandom_range(4095));
                    end
                    push_byte({nib, offset[11:8]}, 1'b0);
                    push_byte(offset[7:0], 1'b0);
                    gen_out += nib + 3;
                end else begin
                    push_byte(8'($urandom_range(255)), 1'b0);
                    gen_out++;
                end
            end
        end
    endtask

    initial begin : stimulus
        int seg;
        int n;
        logic [CFG_W-1:0] dec_len;
        logic [CFG_W-1:0] comp_len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero decoded length: every byte is answered with completion only.
        set_idling(0);
        set_lengths('0, LEN_MAX);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        settle(DRAIN_TAIL);

        // Back-reference with no history, then the halted repeat, then a
        // stream with a clamped, overlapping long copy and a short copy.
        set_idling(1);
        set_lengths(LEN_MAX, LEN_MAX);
        push_byte(8'h80, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h30, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hf0, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'ha5, 1'b0);
        settle(DRAIN_TAIL);

        // A long copy cut short by the decoded length.
        set_idling(2);
        set_lengths(24'd5, LEN_MAX);
        push_byte(8'h20, 1'b1);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'hf0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h77, 1'b0);
        settle(DRAIN_TAIL);

        // Budget spent on a literal, on a flag byte, and before any byte.
        set_idling(3);
        set_lengths(LEN_MAX, 24'd3);
        push_byte(8'h00, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        settle(DRAIN_TAIL);
        set_lengths(LEN_MAX, 24'd1);
        push_byte(8'h80, 1'b1);
        settle(DRAIN_TAIL);
        set_lengths(LEN_MAX, '0);
        push_byte(8'h55, 1'b1);
        settle(DRAIN_TAIL);

        queued_bytes = 0;
        seg = 0;
        while (queued_bytes < 400) begin
            case ($urandom_range(7))
                0: dec_len = LEN_MAX;
                1: dec_len = '0;
                2: dec_len = CFG_W'($urandom_range(1, 24));
                default: dec_len = CFG_W'($urandom_range(25, 600));
            endcase
            case ($urandom_range(5))
                0: comp_len = LEN_MAX;
                1: comp_len = CFG_W'($urandom_range(0, 12));
                default: comp_len = CFG_W'($urandom_range(13, 200));
            endcase
            set_idling(seg);
            set_lengths(dec_len, comp_len);
            // A segment may carry on the previous stream under new lengths.
            add_stream(seg == 0 || $urandom_range(3) != 0, $urandom_range(1, 3));
            if (seg == 2) begin
                settle(0);
                add_stream(1'b0, 1);
            end
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            if ($urandom_range(1) == 0) begin
                add_stream(1'b1, $urandom_range(1, 3));
            end
            settle(DRAIN_TAIL);
            seg++;
        end

        settle(40);
        while (decoded_due.size() != 0) begin
            void'(decoded_due.pop_front());
            report_mismatch("missing result", 0, 1);
        end
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
